// ----- rtl/core/iee_pkg.sv -----
package iee_pkg;

    // Default sizes of the evaluator.
    localparam int STACK_DEPTH_DEF = 128;
    localparam int FRAC_BITS_DEF   = 16;

    // Characters the evaluator knows.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Status codes of a result.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_BAD   = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_OVER  = 3'd3;
    localparam logic [2:0] ST_DIV0  = 3'd4;
    localparam logic [2:0] ST_SAT   = 3'd5;

    // Fraction digits beyond this count are dropped.
    localparam logic [3:0] SCALE_IDX_CAP = 4'd9;

    typedef enum logic [1:0] {
        CLS_DIGIT,
        CLS_COMMA,
        CLS_OPER,
        CLS_BAD
    } sym_class_t;

    // One input transaction.
    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } out_item_t;

    // Classified character as it travels from front to back.
    typedef struct packed {
        sym_class_t cls;
        logic [3:0] digit;
        logic [7:0] op;
        logic       last;
    } token_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_STEP,
        S_CLOSE,
        S_CLWAIT,
        S_OPCHK,
        S_OPR1,
        S_OPR2,
        S_OPR3,
        S_OPPUT,
        S_OPPUT2,
        S_LAST,
        S_FOLD,
        S_FR,
        S_F1,
        S_F2,
        S_F3,
        S_F4,
        S_F4N,
        S_F5,
        S_F6,
        S_EMIT,
        S_CB,
        S_CBMUL,
        S_CBDIV
    } state_t;

    // Power of ten selected by the count of fraction digits.
    function automatic logic [31:0] pow10(input logic [3:0] idx);
        logic [31:0] r;
        case (idx)
            4'd0:    r = 32'd1;
            4'd1:    r = 32'd10;
            4'd2:    r = 32'd100;
            4'd3:    r = 32'd1000;
            4'd4:    r = 32'd10000;
            4'd5:    r = 32'd100000;
            4'd6:    r = 32'd1000000;
            4'd7:    r = 32'd10000000;
            4'd8:    r = 32'd100000000;
            4'd9:    r = 32'd1000000000;
            default: r = 32'd1;
        endcase
        return r;
    endfunction

    // A hard error stops evaluation until the end of the expression.
    function automatic logic is_hard(input logic [2:0] err);
        return (err != ST_OK) && (err != ST_SAT);
    endfunction

    // Hard codes are sticky; saturation may be overwritten.
    function automatic logic [2:0] raise_code(input logic [2:0] err, input logic [2:0] c);
        return ((err == ST_OK) || (err == ST_SAT)) ? c : err;
    endfunction

    // Clamp a sign and magnitude into 32 bits; bit 32 flags saturation.
    function automatic logic [32:0] clamp_mag(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                r = {1'b1, 32'h8000_0000};
            end else begin
                r = {1'b0, 32'h0 - mag[31:0]};
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                r = {1'b1, 32'h7FFF_FFFF};
            end else begin
                r = {1'b0, mag[31:0]};
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/iee_front.sv -----
module iee_front (
    input  logic              symbol_valid,
    input  iee_pkg::in_item_t symbol_item,
    input  logic              q_full,
    output logic              symbol_stall,
    output logic              q_push,
    output iee_pkg::token_t   q_tok
);
    import iee_pkg::*;

    // Stall only while the queue has no room.
    assign symbol_stall = q_full;
    assign q_push       = symbol_valid && !q_full;

    // Sort each character into digit, comma, operator or bad.
    always_comb
    begin
        q_tok.digit = 4'(symbol_item.symbol - CH_ZERO);
        q_tok.op    = symbol_item.symbol;
        q_tok.last  = symbol_item.last;
        if (symbol_item.symbol inside {[CH_ZERO:CH_NINE]}) begin
            q_tok.cls = CLS_DIGIT;
        end else if (symbol_item.symbol == CH_COMMA) begin
            q_tok.cls = CLS_COMMA;
        end else if (symbol_item.symbol inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
            q_tok.cls = CLS_OPER;
        end else begin
            q_tok.cls = CLS_BAD;
        end
    end

endmodule

// ----- rtl/core/iee_queue.sv -----
module iee_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  iee_pkg::token_t push_tok,
    input  logic            pop,
    output logic            full,
    output logic            valid,
    output iee_pkg::token_t head
);
    import iee_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    token_t         entry_reg [DEPTH];
    logic [PW-1:0]  wr_reg, wr_next;
    logic [PW-1:0]  rd_reg, rd_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = entry_reg[rd_reg];

    // Pointer and count update; wrap at the depth.
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Token storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_reg] <= push_tok;
        end
    end

endmodule

// ----- rtl/core/iee_div.sv -----
module iee_div #(
    parameter int NW = 49
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [31:0]   den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [31:0]   rem_reg, rem_next;
    logic [NW-1:0] sh_reg, sh_next;
    logic [31:0]   den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [32:0]   trial;
    logic          fits;

    assign done  = done_reg;
    assign quot  = sh_reg;
    assign trial = {rem_reg, sh_reg[NW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            sh_next   = num;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            sh_next  = {sh_reg[NW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

endmodule

// ----- rtl/core/iee_back.sv -----
module iee_back #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  iee_pkg::token_t    q_tok,
    output logic               q_pop,
    output logic               result_valid,
    input  logic               result_stall,
    output iee_pkg::out_item_t result_item
);
    import iee_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int NW  = 33 + FRAC_BITS;

    // Token stack: bit 32 marks an operator held in bits 7..0.
    logic [32:0]    stack_mem [STACK_DEPTH];
    logic [32:0]    rd_data_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [32:0]    mem_wdata;
    logic [AW-1:0]  mem_raddr;

    state_t         state_reg, state_next;
    state_t         ret_reg, ret_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [31:0]    int_reg, int_next;
    logic [29:0]    fnum_reg, fnum_next;
    logic [3:0]     fidx_reg, fidx_next;
    logic           fdig_reg, fdig_next;
    logic           fcom_reg, fcom_next;
    logic           fstop_reg, fstop_next;
    logic [2:0]     err_reg, err_next;
    token_t         tok_reg, tok_next;
    logic [31:0]    ca_reg, ca_next;
    logic [31:0]    cb_reg, cb_next;
    logic [7:0]     cop_reg, cop_next;
    logic [31:0]    cres_reg, cres_next;
    logic [63:0]    prod_reg, prod_next;
    logic [31:0]    rhs_reg, rhs_next;
    logic [31:0]    lhs_reg, lhs_next;
    logic [7:0]     opr_reg, opr_next;
    logic [7:0]     op2_reg, op2_next;
    logic           hop2_reg, hop2_next;
    logic [31:0]    fin_reg, fin_next;
    logic           rv_reg, rv_next;
    out_item_t      res_reg, res_next;

    logic           div_start;
    logic [NW-1:0]  div_num;
    logic [31:0]    div_den;
    logic           div_done;
    logic [NW-1:0]  div_quot;

    logic [SPW-1:0] sp_m1, sp_m2, sp_m3, sp_m4;
    logic           sp_full;
    logic [31:0]    pw;
    logic [35:0]    int_mul;
    logic [33:0]    fnum_mul;
    logic           cneg;
    logic [31:0]    ma, mb;
    logic [32:0]    sum;
    logic [32:0]    sum_abs;
    logic [63:0]    rnd;
    logic [32:0]    cl_close, cl_mul, cl_div, cl_sum;

    iee_div #(
        .NW(NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign result_valid = rv_reg;
    assign result_item  = res_reg;

    // Stack addresses relative to the top.
    assign sp_m1   = sp_reg - SPW'(1);
    assign sp_m2   = sp_reg - SPW'(2);
    assign sp_m3   = sp_reg - SPW'(3);
    assign sp_m4   = sp_reg - SPW'(4);
    assign sp_full = (sp_reg >= SPW'(STACK_DEPTH));

    // Digit accumulation.
    assign pw       = pow10(fidx_reg);
    assign int_mul  = 36'(int_reg) * 36'd10 + 36'(tok_reg.digit);
    assign fnum_mul = 34'(fnum_reg) * 34'd10 + 34'(tok_reg.digit);

    // Sign and magnitude of the operand pair.
    assign cneg    = ca_reg[31] ^ cb_reg[31];
    assign ma      = ca_reg[31] ? 32'h0 - ca_reg : ca_reg;
    assign mb      = cb_reg[31] ? 32'h0 - cb_reg : cb_reg;
    assign sum     = (cop_reg == CH_MINUS) ? {ca_reg[31], ca_reg} - {cb_reg[31], cb_reg}
                                           : {ca_reg[31], ca_reg} + {cb_reg[31], cb_reg};
    assign sum_abs = sum[32] ? 33'h0 - sum : sum;
    assign rnd     = (prod_reg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

    // Saturating results of each arithmetic path.
    assign cl_close = clamp_mag(1'b0, (64'(int_reg) << FRAC_BITS) + 64'(div_quot));
    assign cl_mul   = clamp_mag(cneg, rnd);
    assign cl_div   = clamp_mag(cneg, 64'(div_quot));
    assign cl_sum   = clamp_mag(sum[32], 64'(sum_abs));

    // Sequencer: number building, operator reduction and the final fold.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        sp_next    = sp_reg;
        int_next   = int_reg;
        fnum_next  = fnum_reg;
        fidx_next  = fidx_reg;
        fdig_next  = fdig_reg;
        fcom_next  = fcom_reg;
        fstop_next = fstop_reg;
        err_next   = err_reg;
        tok_next   = tok_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        cop_next   = cop_reg;
        cres_next  = cres_reg;
        prod_next  = prod_reg;
        rhs_next   = rhs_reg;
        lhs_next   = lhs_reg;
        opr_next   = opr_reg;
        op2_next   = op2_reg;
        hop2_next  = hop2_reg;
        fin_next   = fin_reg;
        rv_next    = rv_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;

        if (rv_reg && !result_stall) begin
            rv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid) begin
                    tok_next   = q_tok;
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                state_next = S_LAST;
                if (!is_hard(err_reg)) begin
                    case (tok_reg.cls)
                        CLS_COMMA:
                        begin
                            if (fcom_reg) begin
                                fstop_next = 1'b1;
                            end else begin
                                fcom_next = 1'b1;
                            end
                        end
                        CLS_DIGIT:
                        begin
                            if (!fstop_reg) begin
                                fdig_next = 1'b1;
                                if (fcom_reg) begin
                                    if (fidx_reg < SCALE_IDX_CAP) begin
                                        fnum_next = fnum_mul[29:0];
                                        fidx_next = fidx_reg + 4'd1;
                                    end
                                end else if (int_mul > 36'h7FFF_FFFF) begin
                                    int_next = 32'h7FFF_FFFF;
                                end else begin
                                    int_next = int_mul[31:0];
                                end
                            end
                        end
                        default:
                        begin
                            ret_next   = S_OPCHK;
                            state_next = S_CLOSE;
                        end
                    endcase
                end
            end

            // Close the pending number: fraction over its power of ten.
            S_CLOSE:
            begin
                if (!fdig_reg) begin
                    err_next   = raise_code(err_reg, ST_EMPTY);
                    state_next = ret_reg;
                end else begin
                    div_start  = 1'b1;
                    div_num    = (NW'(fnum_reg) << FRAC_BITS) + NW'(pw[31:1]);
                    div_den    = pw;
                    state_next = S_CLWAIT;
                end
            end

            S_CLWAIT:
            begin
                if (div_done) begin
                    err_next = cl_close[32] ? raise_code(err_reg, ST_SAT) : err_reg;
                    if (sp_full) begin
                        err_next = raise_code(cl_close[32] ? raise_code(err_reg, ST_SAT)
                                                           : err_reg, ST_OVER);
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = sp_reg[AW-1:0];
                        mem_wdata = {1'b0, cl_close[31:0]};
                        sp_next   = sp_reg + SPW'(1);
                    end
                    int_next   = '0;
                    fnum_next  = '0;
                    fidx_next  = '0;
                    fdig_next  = 1'b0;
                    fcom_next  = 1'b0;
                    fstop_next = 1'b0;
                    state_next = ret_reg;
                end
            end

            // Operator: push it, or first reduce the pair under it.
            S_OPCHK:
            begin
                if (is_hard(err_reg)) begin
                    state_next = S_LAST;
                end else if (tok_reg.cls == CLS_BAD) begin
                    err_next   = raise_code(err_reg, ST_BAD);
                    state_next = S_LAST;
                end else if (sp_reg == SPW'(1)) begin
                    mem_we     = 1'b1;
                    mem_waddr  = sp_reg[AW-1:0];
                    mem_wdata  = {1'b1, 24'h0, tok_reg.op};
                    sp_next    = sp_reg + SPW'(1);
                    state_next = S_LAST;
                end else begin
                    mem_raddr  = sp_m1[AW-1:0];
                    state_next = S_OPR1;
                end
            end

            S_OPR1:
            begin
                rhs_next   = rd_data_reg[31:0];
                mem_raddr  = sp_m2[AW-1:0];
                state_next = S_OPR2;
            end

            S_OPR2:
            begin
                opr_next  = rd_data_reg[7:0];
                mem_raddr = sp_m3[AW-1:0];
                if ((tok_reg.op == CH_STAR || tok_reg.op == CH_SLASH) &&
                    (rd_data_reg[7:0] == CH_PLUS || rd_data_reg[7:0] == CH_MINUS)) begin
                    // Higher precedence: leave the pair and stack the operator.
                    if (sp_full) begin
                        err_next = raise_code(err_reg, ST_OVER);
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = sp_reg[AW-1:0];
                        mem_wdata = {1'b1, 24'h0, tok_reg.op};
                        sp_next   = sp_reg + SPW'(1);
                    end
                    state_next = S_LAST;
                end else begin
                    state_next = S_OPR3;
                end
            end

            S_OPR3:
            begin
                ca_next    = rd_data_reg[31:0];
                cb_next    = rhs_reg;
                cop_next   = opr_reg;
                ret_next   = S_OPPUT;
                state_next = S_CB;
            end

            S_OPPUT:
            begin
                if (is_hard(err_reg)) begin
                    state_next = S_LAST;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = sp_m3[AW-1:0];
                    mem_wdata  = {1'b0, cres_reg};
                    sp_next    = sp_m2;
                    state_next = S_OPPUT2;
                end
            end

            S_OPPUT2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sp_reg[AW-1:0];
                mem_wdata  = {1'b1, 24'h0, tok_reg.op};
                sp_next    = sp_reg + SPW'(1);
                state_next = S_LAST;
            end

            // End of the expression: close the number, then fold.
            S_LAST:
            begin
                if (!tok_reg.last) begin
                    state_next = S_IDLE;
                end else if (is_hard(err_reg)) begin
                    state_next = S_EMIT;
                end else begin
                    ret_next   = S_FOLD;
                    state_next = S_CLOSE;
                end
            end

            S_FOLD:
            begin
                mem_raddr = sp_m1[AW-1:0];
                if (is_hard(err_reg)) begin
                    state_next = S_EMIT;
                end else if (sp_reg > SPW'(2)) begin
                    state_next = S_F1;
                end else if (sp_reg == '0) begin
                    fin_next   = '0;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_FR;
                end
            end

            S_FR:
            begin
                fin_next   = rd_data_reg[31:0];
                state_next = S_EMIT;
            end

            S_F1:
            begin
                rhs_next   = rd_data_reg[31:0];
                mem_raddr  = sp_m2[AW-1:0];
                state_next = S_F2;
            end

            S_F2:
            begin
                opr_next   = rd_data_reg[7:0];
                mem_raddr  = sp_m3[AW-1:0];
                state_next = S_F3;
            end

            S_F3:
            begin
                lhs_next  = rd_data_reg[31:0];
                mem_raddr = sp_m4[AW-1:0];
                if (sp_reg > SPW'(3)) begin
                    state_next = S_F4;
                end else begin
                    hop2_next  = 1'b0;
                    state_next = S_F5;
                end
            end

            // A minus left of the pair becomes a plus of the negated value.
            S_F4:
            begin
                hop2_next = 1'b1;
                op2_next  = rd_data_reg[7:0];
                if (rd_data_reg[7:0] == CH_MINUS) begin
                    op2_next   = CH_PLUS;
                    ca_next    = '0;
                    cb_next    = lhs_reg;
                    cop_next   = CH_MINUS;
                    ret_next   = S_F4N;
                    state_next = S_CB;
                end else begin
                    state_next = S_F5;
                end
            end

            S_F4N:
            begin
                lhs_next   = cres_reg;
                state_next = S_F5;
            end

            S_F5:
            begin
                if (hop2_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = sp_m4[AW-1:0];
                    mem_wdata = {1'b1, 24'h0, op2_reg};
                end
                ca_next    = lhs_reg;
                cb_next    = rhs_reg;
                cop_next   = opr_reg;
                ret_next   = S_F6;
                state_next = S_CB;
            end

            S_F6:
            begin
                if (is_hard(err_reg)) begin
                    state_next = S_EMIT;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = sp_m3[AW-1:0];
                    mem_wdata  = {1'b0, cres_reg};
                    sp_next    = sp_m2;
                    state_next = S_FOLD;
                end
            end

            // Hand the result to the output register and clear for the next one.
            S_EMIT:
            begin
                if (!rv_reg || !result_stall) begin
                    rv_next         = 1'b1;
                    res_next.value  = is_hard(err_reg) ? '0 : $signed(fin_reg);
                    res_next.status = err_reg;
                    sp_next         = '0;
                    err_next        = ST_OK;
                    int_next        = '0;
                    fnum_next       = '0;
                    fidx_next       = '0;
                    fdig_next       = 1'b0;
                    fcom_next       = 1'b0;
                    fstop_next      = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            // Combine two values with one operator.
            S_CB:
            begin
                case (cop_reg)
                    CH_STAR:
                    begin
                        prod_next  = 64'(ma) * 64'(mb);
                        state_next = S_CBMUL;
                    end
                    CH_SLASH:
                    begin
                        if (mb == '0) begin
                            err_next   = raise_code(err_reg, ST_DIV0);
                            cres_next  = '0;
                            state_next = ret_reg;
                        end else begin
                            div_start  = 1'b1;
                            div_num    = (NW'(ma) << FRAC_BITS) + NW'(mb[31:1]);
                            div_den    = mb;
                            state_next = S_CBDIV;
                        end
                    end
                    default:
                    begin
                        cres_next  = cl_sum[31:0];
                        err_next   = cl_sum[32] ? raise_code(err_reg, ST_SAT) : err_reg;
                        state_next = ret_reg;
                    end
                endcase
            end

            S_CBMUL:
            begin
                cres_next  = cl_mul[31:0];
                err_next   = cl_mul[32] ? raise_code(err_reg, ST_SAT) : err_reg;
                state_next = ret_reg;
            end

            S_CBDIV:
            begin
                if (div_done) begin
                    cres_next  = cl_div[31:0];
                    err_next   = cl_div[32] ? raise_code(err_reg, ST_SAT) : err_reg;
                    state_next = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            sp_reg    <= '0;
            int_reg   <= '0;
            fnum_reg  <= '0;
            fidx_reg  <= '0;
            fdig_reg  <= 1'b0;
            fcom_reg  <= 1'b0;
            fstop_reg <= 1'b0;
            err_reg   <= ST_OK;
            rv_reg    <= 1'b0;
            hop2_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            sp_reg    <= sp_next;
            int_reg   <= int_next;
            fnum_reg  <= fnum_next;
            fidx_reg  <= fidx_next;
            fdig_reg  <= fdig_next;
            fcom_reg  <= fcom_next;
            fstop_reg <= fstop_next;
            err_reg   <= err_next;
            rv_reg    <= rv_next;
            hop2_reg  <= hop2_next;
        end
    end

    // Operands and results.
    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        cop_reg  <= cop_next;
        cres_reg <= cres_next;
        prod_reg <= prod_next;
        rhs_reg  <= rhs_next;
        lhs_reg  <= lhs_next;
        opr_reg  <= opr_next;
        op2_reg  <= op2_next;
        fin_reg  <= fin_next;
        res_reg  <= res_next;
    end

    // Stack memory, one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[mem_raddr];
    end

endmodule

// ----- rtl/core/infix_expression_evaluator_core.sv -----
// Closing a number takes a pass through the shared divider, and a divide operator
// another. The back end works one character at a time and pops no new character
// from the queue until it is through with the last, divider passes included; the
// final fold does at least one combine for every operator left on the stack.
// Reset: rst_n clears all control state at once; stack contents are left undefined.
module infix_expression_evaluator_core #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               symbol_valid,
    output logic               symbol_stall,
    input  iee_pkg::in_item_t  symbol_item,
    output logic               result_valid,
    input  logic               result_stall,
    output iee_pkg::out_item_t result_item
);
    import iee_pkg::*;

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    token_t push_tok;
    token_t head_tok;

    // Front end classifies each character.
    iee_front u_front (
        .symbol_valid (symbol_valid),
        .symbol_item  (symbol_item),
        .q_full       (q_full),
        .symbol_stall (symbol_stall),
        .q_push       (q_push),
        .q_tok        (push_tok)
    );

    // Short queue decouples the two halves.
    iee_queue #(
        .DEPTH(2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_tok (push_tok),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (head_tok)
    );

    // Back end evaluates and produces the result transaction.
    iee_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_tok        (head_tok),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule
